### hw/rtl/bmcf_pkg.sv
// shared types and constants for the batch median current filter
package bmcf_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int ACC_BITS       = SAMPLE_BITS + 4;
   localparam int WINDOW_DEFAULT = 16;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;

   typedef struct packed {
      sample_type sample_low;
      sample_type sample_high;
   } req_type;

   typedef struct packed {
      sample_type current_low;
      sample_type current_high;
   } rsp_type;

endpackage

### hw/rtl/batch_median_current_filter.sv
// top level: two-channel batch median filter with exponential smoothing
// throughput: one request per cycle, but requests stall after each batch of WINDOW until its fold
// the request that completes a batch is sorted into the lane buffers, then the fold registers the result
// the stall covers the fold of both medians into the accumulators in the merge stage
// it grows while a finished result waits on rsp_stall
// reset (synchronous, active high) clears fill count, pending flag, accumulators and result valid
module batch_median_current_filter #(
   parameter int WINDOW = bmcf_pkg::WINDOW_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bmcf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bmcf_pkg::rsp_type rsp_data
);

   localparam int FW = $clog2(WINDOW);

   logic [FW-1:0]        fill_ff, fill_in;
   logic                 pending_ff, pending_in;
   logic                 accept;
   logic                 last;
   logic                 out_free;
   logic                 fold_en;
   bmcf_pkg::sample_type median_low;
   bmcf_pkg::sample_type median_high;

   // hold off requests while a completed batch waits for its fold
   assign req_stall = pending_ff;
   assign accept    = req_valid && !pending_ff;
   assign last      = fill_ff == FW'(WINDOW - 1);

   // fold once the result register can take the new result
   assign fold_en   = pending_ff && out_free;

   always_comb begin
      fill_in    = fill_ff;
      pending_in = pending_ff;
      if (accept) begin
         fill_in = last ? '0 : fill_ff + FW'(1);
         if (last) begin
            pending_in = 1'b1;
         end
      end else if (fold_en) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         pending_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         pending_ff <= pending_in;
      end
   end

   // low-side lane
   bmcf_lane #(
      .WINDOW (WINDOW),
      .FW     (FW)
   ) u_lane_low (
      .clock  (clock),
      .load   (accept),
      .fill   (fill_ff),
      .sample (req_data.sample_low),
      .median (median_low)
   );

   // high-side lane
   bmcf_lane #(
      .WINDOW (WINDOW),
      .FW     (FW)
   ) u_lane_high (
      .clock  (clock),
      .load   (accept),
      .fill   (fill_ff),
      .sample (req_data.sample_high),
      .median (median_high)
   );

   // merge: smoothing and result register
   bmcf_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .fold_en     (fold_en),
      .median_low  (median_low),
      .median_high (median_high),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .out_free    (out_free)
   );

endmodule

### hw/rtl/bmcf_lane.sv
// one channel lane: sorted insertion buffer with a fixed median tap
module bmcf_lane #(
   parameter int WINDOW = bmcf_pkg::WINDOW_DEFAULT,
   parameter int FW     = $clog2(WINDOW)
) (
   input  logic                 clock,
   input  logic                 load,
   input  logic [FW-1:0]        fill,
   input  bmcf_pkg::sample_type sample,
   output bmcf_pkg::sample_type median
);

   bmcf_pkg::sample_type buf_ff [WINDOW];
   bmcf_pkg::sample_type buf_in [WINDOW];
   logic [WINDOW-1:0]    held;
   logic [WINDOW-1:0]    keep;
   logic [WINDOW-1:0]    shift;

   // each cell keeps its value, takes its left neighbor, or takes the new sample
   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         held[i]  = i < int'(fill);
         keep[i]  = held[i] && (buf_ff[i] <= sample);
         shift[i] = held[i] && (buf_ff[i] > sample);
      end
      for (int i = 0; i < WINDOW; i++) begin
         if (keep[i]) begin
            buf_in[i] = buf_ff[i];
         end else if (i > 0 && shift[(i > 0) ? i - 1 : 0]) begin
            buf_in[i] = buf_ff[(i > 0) ? i - 1 : 0];
         end else begin
            buf_in[i] = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= buf_in;
      end
   end

   assign median = buf_ff[WINDOW/2];

endmodule

### hw/rtl/bmcf_merge.sv
// smoothing accumulators for both lanes and the result register
module bmcf_merge (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fold_en,
   input  bmcf_pkg::sample_type median_low,
   input  bmcf_pkg::sample_type median_high,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output bmcf_pkg::rsp_type    rsp_data,
   output logic                 out_free
);

   localparam int DW = bmcf_pkg::ACC_BITS + 1;

   bmcf_pkg::acc_type acc_low_ff, acc_low_in;
   bmcf_pkg::acc_type acc_high_ff, acc_high_in;
   logic              valid_ff, valid_in;
   bmcf_pkg::rsp_type data_ff, data_in;

   // acc + (median*8 - acc)/8, division toward zero
   function automatic bmcf_pkg::acc_type fold(bmcf_pkg::acc_type acc,
                                              bmcf_pkg::sample_type med);
      logic signed [DW-1:0] diff;
      logic signed [DW-1:0] biased;
      logic signed [DW-1:0] quot;
      diff   = (DW'(med) <<< 3) - DW'(acc);
      biased = diff + (diff[DW-1] ? DW'(7) : DW'(0));
      quot   = biased >>> 3;
      return acc + bmcf_pkg::ACC_BITS'(quot);
   endfunction

   // acc / 8 toward zero
   function automatic bmcf_pkg::sample_type scale(bmcf_pkg::acc_type acc);
      bmcf_pkg::acc_type biased;
      bmcf_pkg::acc_type quot;
      biased = acc + (acc[bmcf_pkg::ACC_BITS-1] ? bmcf_pkg::ACC_BITS'(7)
                                                : bmcf_pkg::ACC_BITS'(0));
      quot   = biased >>> 3;
      return bmcf_pkg::SAMPLE_BITS'(quot);
   endfunction

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      acc_low_in  = acc_low_ff;
      acc_high_in = acc_high_ff;
      data_in     = data_ff;
      valid_in    = valid_ff && rsp_stall;
      if (fold_en) begin
         acc_low_in           = fold(acc_low_ff, median_low);
         acc_high_in          = fold(acc_high_ff, median_high);
         data_in.current_low  = scale(acc_low_in);
         data_in.current_high = scale(acc_high_in);
         valid_in             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_low_ff  <= '0;
         acc_high_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         acc_low_ff  <= acc_low_in;
         acc_high_ff <= acc_high_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
